[rtl/core/trained_repetition_counter_top_defines.svh]
// ----------------------------------------------------------------------------
// Trained repetition counter assertion macros
// Concurrent assertion helpers that use clk and arst_n of the including scope.
// ----------------------------------------------------------------------------
`ifndef TRAINED_REPETITION_COUNTER_TOP_DEFINES_SVH
`define TRAINED_REPETITION_COUNTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TRC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TRC_ASSERT_SAME(lbl, ante, cons, msg)
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/trc_pkg.sv]
// ----------------------------------------------------------------------------
// Trained repetition counter package
// Widths, reset values, register indexes and payload types.
// ----------------------------------------------------------------------------
package trc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int REP_W    = 16;
	localparam int CFG_W    = 16;
	localparam int TCNT_W   = 8;
	localparam int SCALE_W  = 8;
	localparam int AXIS_W   = 2;

	localparam logic [TCNT_W-1:0]         RST_TRAIN_TARGET   = TCNT_W'(10);
	localparam logic signed [CFG_W-1:0]   RST_BASE_UP        = CFG_W'(16384);
	localparam logic signed [CFG_W-1:0]   RST_BASE_DOWN      = -CFG_W'(16384);
	localparam logic [SCALE_W-1:0]        RST_SCALE          = SCALE_W'(179);

	typedef enum logic [1:0] {
		CFG_TRAIN_TARGET   = 2'd0,
		CFG_BASE_UP        = 2'd1,
		CFG_BASE_DOWN      = 2'd2,
		CFG_SCALE          = 2'd3
	} cfg_idx_t;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic [TCNT_W-1:0]       train_target;
		logic signed [CFG_W-1:0] base_up_threshold;
		logic signed [CFG_W-1:0] base_down_threshold;
		logic [SCALE_W-1:0]      threshold_scale;
	} cfg_t;

	typedef struct packed {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} in_req_t;

	typedef struct packed {
		logic                       counting_phase;
		logic [TCNT_W-1:0]          training_reps;
		logic [REP_W-1:0]           rep_count;
		logic                       moving_up;
		logic                       rep_detected;
		logic                       training_rep_detected;
		logic [AXIS_W-1:0]          selected_axis;
		logic signed [SAMPLE_W-1:0] trained_up_level;
		logic signed [SAMPLE_W-1:0] trained_down_level;
	} out_req_t;

	typedef struct packed {
		axis_t                      axis;
		logic signed [SAMPLE_W-1:0] sample;
	} axis_sel_t;

endpackage

[rtl/core/trained_repetition_counter_top.sv]
// ----------------------------------------------------------------------------
// Trained repetition counter top level
// Engine state updates in a single pass between input and output registers.
// Throughput: one request per cycle while out_stall does not hold the output.
// The input register and the output register each hold one request.
// Reset clears all engine state, both valid flags and restores the configuration.
// ----------------------------------------------------------------------------
`include "trained_repetition_counter_top_defines.svh"

module trained_repetition_counter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  trc_pkg::in_req_t            in_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output trc_pkg::out_req_t           out_req,
	input  logic                        cfg_we,
	input  trc_pkg::cfg_idx_t           cfg_idx,
	input  logic [trc_pkg::CFG_W-1:0]   cfg_data
);

	trc_pkg::cfg_t     cfg_q;
	logic              in_valid_s1;
	trc_pkg::in_req_t  in_req_s1;
	logic              out_valid_s2;
	trc_pkg::out_req_t out_req_s2;
	trc_pkg::out_req_t res;
	logic              adv;

	assign adv       = in_valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall  = in_valid_s1 && !adv;
	assign out_valid = out_valid_s2;
	assign out_req   = out_req_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.train_target        <= trc_pkg::RST_TRAIN_TARGET;
			cfg_q.base_up_threshold   <= trc_pkg::RST_BASE_UP;
			cfg_q.base_down_threshold <= trc_pkg::RST_BASE_DOWN;
			cfg_q.threshold_scale     <= trc_pkg::RST_SCALE;
		end else if (cfg_we) begin
			case (cfg_idx)
				trc_pkg::CFG_TRAIN_TARGET: begin
					cfg_q.train_target <= cfg_data[trc_pkg::TCNT_W-1:0];
				end
				trc_pkg::CFG_BASE_UP:        cfg_q.base_up_threshold <= cfg_data;
				trc_pkg::CFG_BASE_DOWN:      cfg_q.base_down_threshold <= cfg_data;
				trc_pkg::CFG_SCALE: begin
					cfg_q.threshold_scale <= cfg_data[trc_pkg::SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_req_s1 <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_req_s2 <= res;
		end
	end

	trc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (in_req_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	`TRC_ASSERT_SAME(a_one_detect, out_valid_s2, !(out_req_s2.rep_detected && out_req_s2.training_rep_detected), "both detect flags set")
	`TRC_ASSERT_SAME(a_rep_counting, out_valid_s2 && out_req_s2.rep_detected, out_req_s2.counting_phase && !out_req_s2.moving_up, "counted repetition outside counting")
	`TRC_ASSERT_SAME(a_train_rep, out_valid_s2 && out_req_s2.training_rep_detected, !out_req_s2.moving_up && (out_req_s2.training_reps != '0), "training repetition with bad state")
	`TRC_ASSERT_NEXT(a_restart, adv && in_req_s1.cmd, out_valid_s2 && (out_req_s2.training_reps == '0) && !out_req_s2.rep_detected, "restart left training progress")

endmodule

[rtl/core/trc_axis_sel.sv]
// ----------------------------------------------------------------------------
// Trained repetition counter axis selection
// Picks the dominant axis until the first training rep and routes its sample.
// ----------------------------------------------------------------------------
module trc_axis_sel (
	input  trc_pkg::in_req_t   req,
	input  logic               locked,
	input  trc_pkg::axis_t     cur_axis,
	output trc_pkg::axis_sel_t sel
);

	logic [trc_pkg::SAMPLE_W:0] mag_x;
	logic [trc_pkg::SAMPLE_W:0] mag_y;
	logic [trc_pkg::SAMPLE_W:0] mag_z;
	trc_pkg::axis_t             pick;

	function automatic logic [trc_pkg::SAMPLE_W:0] magnitude(
		input logic signed [trc_pkg::SAMPLE_W-1:0] v
	);
		logic [trc_pkg::SAMPLE_W:0] ext;
		ext = {v[trc_pkg::SAMPLE_W-1], v};
		return v[trc_pkg::SAMPLE_W-1] ? (~ext + 1'b1) : ext;
	endfunction

	always_comb begin
		mag_x = magnitude(req.accel_x);
		mag_y = magnitude(req.accel_y);
		mag_z = magnitude(req.accel_z);
		if (mag_x > mag_y && mag_x > mag_z) begin
			pick = trc_pkg::AXIS_X;
		end else if (mag_y > mag_x && mag_y > mag_z) begin
			pick = trc_pkg::AXIS_Y;
		end else begin
			pick = trc_pkg::AXIS_Z;
		end
		sel.axis = locked ? cur_axis : pick;
		case (sel.axis)
			trc_pkg::AXIS_X: sel.sample = req.accel_x;
			trc_pkg::AXIS_Y: sel.sample = req.accel_y;
			default:         sel.sample = req.accel_z;
		endcase
	end

endmodule

[rtl/core/trc_engine.sv]
// ----------------------------------------------------------------------------
// Trained repetition counter engine
// Holds the training and counting state and updates it once per request.
// ----------------------------------------------------------------------------
module trc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  trc_pkg::in_req_t  req,
	input  trc_pkg::cfg_t     cfg,
	output trc_pkg::out_req_t res
);

	localparam int SW = trc_pkg::SAMPLE_W;

	trc_pkg::axis_t                axis_q, axis_n;
	logic                          up_q, up_n;
	logic [trc_pkg::TCNT_W-1:0]    done_q, done_n;
	logic [trc_pkg::REP_W-1:0]     reps_q, reps_n;
	logic signed [SW-1:0]          peak_hi_q, peak_hi_n;
	logic signed [SW-1:0]          peak_lo_q, peak_lo_n;
	logic signed [SW-1:0]          lvl_up_q, lvl_up_n;
	logic signed [SW-1:0]          lvl_dn_q, lvl_dn_n;
	logic                          rep_hit;
	logic                          train_hit;
	trc_pkg::axis_sel_t            sel;
	logic signed [SW-1:0]          v;

	function automatic logic signed [SW-1:0] scale_level(
		input logic signed [SW-1:0]        peak,
		input logic [trc_pkg::SCALE_W-1:0] scale
	);
		logic [SW:0]                   ext;
		logic [SW:0]                   mag;
		logic [SW+trc_pkg::SCALE_W:0]  prod;
		logic [SW:0]                   q;
		logic [SW:0]                   sq;
		ext  = {peak[SW-1], peak};
		mag  = peak[SW-1] ? (~ext + 1'b1) : ext;
		prod = (SW+trc_pkg::SCALE_W+1)'(mag) * (SW+trc_pkg::SCALE_W+1)'(scale);
		q    = prod[SW+trc_pkg::SCALE_W:trc_pkg::SCALE_W];
		sq   = peak[SW-1] ? (~q + 1'b1) : q;
		return sq[SW-1:0];
	endfunction

	trc_axis_sel u_axis_sel (
		.req      (req),
		.locked   (done_q != '0),
		.cur_axis (axis_q),
		.sel      (sel)
	);

	assign v = sel.sample;

	always_comb begin
		axis_n    = axis_q;
		up_n      = up_q;
		done_n    = done_q;
		reps_n    = reps_q;
		peak_hi_n = peak_hi_q;
		peak_lo_n = peak_lo_q;
		lvl_up_n  = lvl_up_q;
		lvl_dn_n  = lvl_dn_q;
		rep_hit   = 1'b0;
		train_hit = 1'b0;
		if (req.cmd) begin
			if (done_q != '0) begin
				axis_n    = trc_pkg::AXIS_X;
				up_n      = 1'b0;
				done_n    = '0;
				reps_n    = '0;
				peak_hi_n = '0;
				peak_lo_n = '0;
				lvl_up_n  = '0;
				lvl_dn_n  = '0;
			end
		end else begin
			axis_n = sel.axis;
			if (done_q < cfg.train_target) begin
				if (v > peak_hi_q) begin
					peak_hi_n = v;
				end
				if (v < peak_lo_q) begin
					peak_lo_n = v;
				end
				if (v > cfg.base_up_threshold && !up_q) begin
					up_n = 1'b1;
				end else if (v < cfg.base_down_threshold && up_q) begin
					up_n      = 1'b0;
					done_n    = done_q + 1'b1;
					train_hit = 1'b1;
				end
				if (done_n == cfg.train_target) begin
					lvl_up_n = scale_level(peak_hi_n, cfg.threshold_scale);
					lvl_dn_n = scale_level(peak_lo_n, cfg.threshold_scale);
				end
			end else begin
				if (v > lvl_up_q && !up_q) begin
					up_n = 1'b1;
				end else if (v < lvl_dn_q && up_q) begin
					up_n    = 1'b0;
					rep_hit = 1'b1;
					if (reps_q != '1) begin
						reps_n = reps_q + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res.counting_phase        = (done_n >= cfg.train_target);
		res.training_reps         = done_n;
		res.rep_count             = reps_n;
		res.moving_up             = up_n;
		res.rep_detected          = rep_hit;
		res.training_rep_detected = train_hit;
		res.selected_axis         = axis_n;
		res.trained_up_level      = lvl_up_n;
		res.trained_down_level    = lvl_dn_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q    <= trc_pkg::AXIS_X;
			up_q      <= 1'b0;
			done_q    <= '0;
			reps_q    <= '0;
			peak_hi_q <= '0;
			peak_lo_q <= '0;
			lvl_up_q  <= '0;
			lvl_dn_q  <= '0;
		end else if (adv) begin
			axis_q    <= axis_n;
			up_q      <= up_n;
			done_q    <= done_n;
			reps_q    <= reps_n;
			peak_hi_q <= peak_hi_n;
			peak_lo_q <= peak_lo_n;
			lvl_up_q  <= lvl_up_n;
			lvl_dn_q  <= lvl_dn_n;
		end
	end

endmodule

[verif/tb_trained_repetition_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trained repetition counter testbench
// Drives directed and random accelerometer requests through the valid/stall
// handshake with random gaps and stalls, predicts every result with an
// independent model of the training and counting rules, and checks each
// result field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_trained_repetition_counter_top;
	import trc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP   = 20;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_req_t           in_req   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_req_t          out_req;
	logic              cfg_we   = 1'b0;
	cfg_idx_t          cfg_idx  = CFG_TRAIN_TARGET;
	logic [CFG_W-1:0]  cfg_data = '0;

	trained_repetition_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	in_req_t  pending_reqs[$];
	out_req_t predicted_reports[$];

	logic [TCNT_W-1:0]         reg_train_count;
	logic signed [CFG_W-1:0]   reg_base_up;
	logic signed [CFG_W-1:0]   reg_base_dn;
	logic [SCALE_W-1:0]        reg_scale;

	axis_t                     cnt_axis;
	logic                      cnt_up;
	logic [TCNT_W-1:0]         cnt_trained;
	logic [REP_W-1:0]          cnt_reps;
	logic signed [SAMPLE_W-1:0] peak_hi;
	logic signed [SAMPLE_W-1:0] peak_lo;
	logic signed [SAMPLE_W-1:0] level_up;
	logic signed [SAMPLE_W-1:0] level_dn;

	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	bit in_taken  = 1'b0;
	int gap_left     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int cycles       = 0;

	int mismatches    = 0;
	int reqs_seen     = 0;
	int restarts_seen = 0;
	int results_seen  = 0;
	int cfg_writes    = 0;
	int training_hits = 0;
	int counted_hits  = 0;
	int top_count     = 0;

	function automatic void clear_counter();
		cnt_axis    = AXIS_X;
		cnt_up      = 1'b0;
		cnt_trained = '0;
		cnt_reps    = '0;
		peak_hi     = '0;
		peak_lo     = '0;
		level_up    = '0;
		level_dn    = '0;
	endfunction

	function automatic void set_register(cfg_idx_t idx, logic [CFG_W-1:0] val);
		case (idx)
			CFG_TRAIN_TARGET:   reg_train_count = val[TCNT_W-1:0];
			CFG_BASE_UP:        reg_base_up = val;
			CFG_BASE_DOWN:      reg_base_dn = val;
			CFG_SCALE:          reg_scale = val[SCALE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] scaled_level(
			logic signed [SAMPLE_W-1:0] peak);
		longint mag;
		mag = longint'(peak);
		if (mag < 0)
			mag = -mag;
		mag = (mag * longint'(reg_scale)) / 256;
		return (peak < 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
	endfunction

	function automatic out_req_t count_step(in_req_t r);
		out_req_t o;
		int ax, ay, az, mx, my, mz, v;
		bit rep_hit, train_hit;
		ax = int'(r.accel_x);
		ay = int'(r.accel_y);
		az = int'(r.accel_z);
		rep_hit = 1'b0;
		train_hit = 1'b0;
		if (r.cmd) begin
			if (cnt_trained != 0)
				clear_counter();
		end else begin
			if (cnt_trained == 0) begin
				mx = (ax < 0) ? -ax : ax;
				my = (ay < 0) ? -ay : ay;
				mz = (az < 0) ? -az : az;
				if (mx > my && mx > mz)
					cnt_axis = AXIS_X;
				else if (my > mx && my > mz)
					cnt_axis = AXIS_Y;
				else
					cnt_axis = AXIS_Z;
			end
			case (cnt_axis)
				AXIS_X:  v = ax;
				AXIS_Y:  v = ay;
				default: v = az;
			endcase
			if (cnt_trained < reg_train_count) begin
				if (v > peak_hi)
					peak_hi = SAMPLE_W'(v);
				if (v < peak_lo)
					peak_lo = SAMPLE_W'(v);
				if (v > reg_base_up && !cnt_up) begin
					cnt_up = 1'b1;
				end else if (v < reg_base_dn && cnt_up) begin
					cnt_up = 1'b0;
					cnt_trained++;
					train_hit = 1'b1;
				end
				if (cnt_trained == reg_train_count) begin
					level_up = scaled_level(peak_hi);
					level_dn = scaled_level(peak_lo);
				end
			end else begin
				if (v > level_up && !cnt_up) begin
					cnt_up = 1'b1;
				end else if (v < level_dn && cnt_up) begin
					cnt_up = 1'b0;
					if (cnt_reps != '1)
						cnt_reps++;
					rep_hit = 1'b1;
				end
			end
		end
		o.counting_phase        = (cnt_trained >= reg_train_count);
		o.training_reps         = cnt_trained;
		o.rep_count             = cnt_reps;
		o.moving_up             = cnt_up;
		o.rep_detected          = rep_hit;
		o.training_rep_detected = train_hit;
		o.selected_axis         = cnt_axis;
		o.trained_up_level      = level_up;
		o.trained_down_level    = level_dn;
		return o;
	endfunction

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(20, 4);
	endfunction

	function automatic in_req_t noise_req(bit restart);
		in_req_t r;
		r.cmd = restart;
		r.accel_x = SAMPLE_W'($urandom);
		r.accel_y = SAMPLE_W'($urandom);
		r.accel_z = SAMPLE_W'($urandom);
		return r;
	endfunction

	function automatic in_req_t sample_req(int x, int y, int z);
		in_req_t r;
		r.cmd = 1'b0;
		r.accel_x = SAMPLE_W'(x);
		r.accel_y = SAMPLE_W'(y);
		r.accel_z = SAMPLE_W'(z);
		return r;
	endfunction

	function automatic in_req_t axis_req(axis_t ax, int dom);
		in_req_t r;
		int m;
		m = ((dom < 0) ? -dom : dom) / 3;
		r = sample_req(rnd(-m, m), rnd(-m, m), rnd(-m, m));
		case (ax)
			AXIS_X:  r.accel_x = SAMPLE_W'(dom);
			AXIS_Y:  r.accel_y = SAMPLE_W'(dom);
			default: r.accel_z = SAMPLE_W'(dom);
		endcase
		return r;
	endfunction

	task automatic push_reps(int n, int peak_min, int mess_pct);
		axis_t ax;
		int k, j, highs, lows;
		ax = axis_t'($urandom_range(2));
		for (k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0)
				ax = axis_t'($urandom_range(2));
			if ($urandom_range(99) < mess_pct)
				pending_reqs.push_back(noise_req($urandom_range(5) == 0));
			highs = $urandom_range(2, 1);
			lows = ($urandom_range(99) < mess_pct / 2) ? 0 : $urandom_range(2, 1);
			for (j = 0; j < highs; j++)
				pending_reqs.push_back(axis_req(ax, rnd(peak_min, 32767)));
			if ($urandom_range(99) < 25)
				pending_reqs.push_back(axis_req(ax, rnd(-peak_min / 2, peak_min / 2)));
			for (j = 0; j < lows; j++)
				pending_reqs.push_back(axis_req(ax, rnd(-32768, -peak_min)));
		end
	endtask

	task automatic cfg_write(cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int tc, int up, int dn, int sc);
		cfg_write(CFG_TRAIN_TARGET, tc);
		cfg_write(CFG_BASE_UP, up);
		cfg_write(CFG_BASE_DOWN, dn);
		cfg_write(CFG_SCALE, sc);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || predicted_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic compare_field(string fname, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("trained_repetition_counter_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk)
		in_taken <= arst_n && in_valid && !in_stall;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				in_req   <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				gap_left <= draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int r;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= 59;
			out_stall    <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stalls_on) begin
			r = $urandom_range(99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else if (r < 95) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(3);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(25, 8);
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_req_t want;
		if (arst_n) begin
			if (cfg_we) begin
				set_register(cfg_idx, cfg_data);
				cfg_writes++;
			end
			if (in_valid && !in_stall) begin
				predicted_reports.push_back(count_step(in_req));
				reqs_seen++;
				if (in_req.cmd)
					restarts_seen++;
			end
			if (out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= PRINT_CAP)
						$display("%0t: result expected none actual %h", $time, out_req);
				end else begin
					want = predicted_reports.pop_front();
					compare_field("counting_phase", want.counting_phase,
						out_req.counting_phase);
					compare_field("training_reps", want.training_reps, out_req.training_reps);
					compare_field("rep_count", want.rep_count, out_req.rep_count);
					compare_field("moving_up", want.moving_up, out_req.moving_up);
					compare_field("rep_detected", want.rep_detected, out_req.rep_detected);
					compare_field("training_rep_detected", want.training_rep_detected,
						out_req.training_rep_detected);
					compare_field("selected_axis", want.selected_axis, out_req.selected_axis);
					compare_field("trained_up_level", want.trained_up_level,
						out_req.trained_up_level);
					compare_field("trained_down_level", want.trained_down_level,
						out_req.trained_down_level);
					results_seen++;
					if (out_req.training_rep_detected === 1'b1)
						training_hits++;
					if (out_req.rep_detected === 1'b1)
						counted_hits++;
					if (int'(out_req.rep_count) > top_count)
						top_count = int'(out_req.rep_count);
				end
			end
		end
	end

	initial begin
		int k;
		clear_counter();
		reg_train_count = RST_TRAIN_TARGET;
		reg_base_up     = RST_BASE_UP;
		reg_base_dn     = RST_BASE_DOWN;
		reg_scale       = RST_SCALE;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: axis ties, threshold boundaries, restarts.
		pending_reqs.push_back(noise_req(1'b1));
		pending_reqs.push_back(sample_req(0, 0, 0));
		pending_reqs.push_back(sample_req(-32768, 32767, 0));
		pending_reqs.push_back(sample_req(100, 32767, -100));
		pending_reqs.push_back(sample_req(5, 5, -32768));
		pending_reqs.push_back(sample_req(32767, 32767, 0));
		pending_reqs.push_back(sample_req(16384, 0, 16384));
		pending_reqs.push_back(sample_req(0, 0, 16385));
		pending_reqs.push_back(sample_req(0, 0, -16384));
		pending_reqs.push_back(sample_req(0, 0, -16385));
		pending_reqs.push_back(sample_req(-1, -1, -1));
		pending_reqs.push_back(noise_req(1'b1));
		pending_reqs.push_back(sample_req(30000, 30000, 0));
		pending_reqs.push_back(sample_req(-30000, 30000, 1));
		pending_reqs.push_back(sample_req(0, -32768, 0));
		pending_reqs.push_back(sample_req(0, 32767, 32767));
		pending_reqs.push_back(sample_req(-32768, -32768, -32768));
		pending_reqs.push_back(sample_req(32767, -32768, 32767));
		pending_reqs.push_back(sample_req(0, 0, -32768));
		drain();

		set_config(2, 8000, -8000, 255);
		push_reps(16, 9000, 20);
		drain();
		gaps_on = 1'b0;
		holds_asked++;
		push_reps(10, 9000, 0);
		drain();
		gaps_on = 1'b1;
		push_reps(3, 9000, 0);
		drain();

		// Training count dropped to or below the trained count, then raised.
		cfg_write(CFG_TRAIN_TARGET, 1);
		push_reps(12, 9000, 20);
		drain();
		set_config(200, -32768, 32767, 0);
		push_reps(12, 0, 30);
		drain();

		cfg_write(CFG_TRAIN_TARGET, 0);
		pending_reqs.push_back(noise_req(1'b1));
		push_reps(12, 5000, 20);
		drain();

		set_config(255, 32767, -16384, 179);
		push_reps(8, 17000, 30);
		drain();
		set_config(255, 16384, -32768, 179);
		push_reps(8, 17000, 30);
		drain();
		cfg_write(CFG_BASE_DOWN, -16384);
		cfg_write(CFG_TRAIN_TARGET, 8);
		pending_reqs.push_back(noise_req(1'b1));
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		push_reps(12, 17000, 0);
		drain();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		push_reps(8, 17000, 20);
		drain();

		for (k = 0; k < 3; k++) begin
			set_config(rnd(1, 4), rnd(4000, 20000), -rnd(4000, 20000), $urandom_range(255));
			if ($urandom_range(1))
				pending_reqs.push_back(noise_req(1'b1));
			push_reps(6, 21000, 15);
			drain();
		end

		// A single training repetition, then counting back to back.
		set_config(1, 16384, -16384, 128);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		pending_reqs.push_back(noise_req(1'b1));
		push_reps(8, 17000, 0);
		drain();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		push_reps(6, 17000, 30);
		drain();
		repeat (10) @(posedge clk);

		if (predicted_reports.size() != 0) begin
			mismatches++;
			$display("%0t: results expected %0d more actual 0", $time,
				predicted_reports.size());
		end
		$display("Run covered %0d requests with %0d restarts and %0d register writes.",
			reqs_seen, restarts_seen, cfg_writes);
		$display("Checked %0d results: %0d training reps, %0d counted reps, peak count %0d.",
			results_seen, training_hits, counted_hits, top_count);
		if (mismatches == 0)
			$display("trained_repetition_counter_top: match");
		else
			$display("trained_repetition_counter_top: mismatch");
		$finish;
	end

endmodule
